// ===== sv/mie_pkg.sv =====
// Package for the modular inverse block: word width, word type and the
// request and response structs between the sequencer and the divide unit.
// No dependencies.
package mie_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(1000000007);

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
    word_t mult;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t rem;
    word_t acc;
  } div_rsp_t;

endpackage

// ===== sv/mie_if.sv =====
// Handshake channels of the modular inverse block: operand, result and
// configuration write. Depends on mie_pkg.
interface mie_value_if;
  logic             valid;
  logic             ready;
  mie_pkg::word_t   value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface mie_result_if;
  logic             valid;
  logic             ready;
  mie_pkg::word_t   inverse;
  logic             exists;
  modport source (output valid, output inverse, output exists, input ready);
  modport sink (input valid, input inverse, input exists, output ready);
endinterface

interface mie_cfg_if;
  logic             valid;
  logic             ready;
  mie_pkg::word_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/mie_div.sv =====
// Bit-serial restoring divider with a fused quotient multiply-accumulate:
// gives dividend mod divisor and quotient times mult, one bit a cycle.
// Depends on mie_pkg.
module mie_div (
  input  logic              clk,
  input  logic              rst,
  input  mie_pkg::div_req_t req,
  output mie_pkg::div_rsp_t rsp
);

  logic                      busy;
  logic [mie_pkg::CNT_W-1:0] cnt;
  mie_pkg::word_t            rem;
  mie_pkg::word_t            quo;
  mie_pkg::word_t            acc;
  mie_pkg::word_t            dvs;
  mie_pkg::word_t            mul;
  logic                      done;

  logic [mie_pkg::WIDTH:0]   shifted;
  logic                      qbit;
  logic                      last;

  assign shifted = {rem, quo[mie_pkg::WIDTH-1]};
  assign qbit    = shifted >= {1'b0, dvs};
  assign last    = cnt == mie_pkg::CNT_W'(mie_pkg::WIDTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      acc <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
      mul <= req.mult;
    end else if (busy) begin
      rem <= qbit ? mie_pkg::WIDTH'(shifted - {1'b0, dvs})
                  : shifted[mie_pkg::WIDTH-1:0];
      quo <= {quo[mie_pkg::WIDTH-2:0], 1'b0};
      acc <= {acc[mie_pkg::WIDTH-2:0], 1'b0} + (qbit ? mul : '0);
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;
  assign rsp.acc  = acc;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("Divider started while busy.");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dvs)
    else $error("Remainder not below divisor.");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Done held longer than one cycle.");

endmodule

// ===== sv/modular_inverse_ext_euclid.sv =====
// Modular inverse by the extended Euclidean algorithm, one item at a time.
// The operand is reduced by the modulus and then each Euclid step divides, both in
// the shared bit-serial divider; check, normalization and output follow. A modulus
// of 0 skips the divider and gives no inverse.
// A new item is taken while a result waits.
// Reset: modulus returns to 1000000007 and all control state clears.
module modular_inverse_ext_euclid (
  input  logic                clk,
  input  logic                rst,
  mie_cfg_if.sink             cfg,
  mie_value_if.sink           operand,
  mie_result_if.source        result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_NORM = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state;
  mie_pkg::word_t    modulus;
  mie_pkg::word_t    r0;
  mie_pkg::word_t    r1;
  mie_pkg::word_t    t0;
  mie_pkg::word_t    t1;
  mie_pkg::word_t    tred;
  logic              par;
  logic              ok;
  logic              out_valid;
  mie_pkg::word_t    out_inverse;
  logic              out_exists;

  mie_pkg::div_req_t dreq;
  mie_pkg::div_rsp_t drsp;
  mie_pkg::word_t    inv_next;
  logic              in_fire;

  assign cfg.ready     = 1'b1;
  assign operand.ready = state == S_IDLE;
  assign in_fire       = operand.valid && operand.ready;

  assign result.valid   = out_valid;
  assign result.inverse = out_inverse;
  assign result.exists  = out_exists;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = r0;
    dreq.divisor  = r1;
    dreq.mult     = t1;
    if (state == S_IDLE && in_fire && modulus != '0) begin
      dreq.start    = 1'b1;
      dreq.dividend = operand.value;
      dreq.divisor  = modulus;
      dreq.mult     = '0;
    end else if (state == S_CHK && r1 != '0) begin
      dreq.start = 1'b1;
    end
  end

  always_comb begin
    if (!ok) begin
      inv_next = '0;
    end else if (!par && tred != '0) begin
      inv_next = modulus - tred;
    end else begin
      inv_next = tred;
    end
  end

  mie_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mie_pkg::MODULUS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      modulus <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (result.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            r0    <= modulus;
            r1    <= '0;
            t0    <= '0;
            t1    <= mie_pkg::WIDTH'(1);
            par   <= 1'b0;
            state <= (modulus != '0) ? S_RED : S_CHK;
          end
        end
        S_RED: begin
          if (drsp.done) begin
            r1    <= drsp.rem;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          state <= (r1 != '0) ? S_DIV : S_NORM;
        end
        S_DIV: begin
          if (drsp.done) begin
            r0    <= r1;
            r1    <= drsp.rem;
            t0    <= t1;
            t1    <= drsp.acc + t0;
            par   <= !par;
            state <= S_CHK;
          end
        end
        S_NORM: begin
          tred  <= (t0 >= modulus) ? t0 - modulus : t0;
          ok    <= r0 == mie_pkg::WIDTH'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_inverse <= inv_next;
            out_exists  <= ok;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !operand.ready)
    else $error("Operand taken while an item is in progress.");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == S_RED || state == S_DIV))
    else $error("Divider finished outside a division state.");

  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.exists |-> result.inverse == '0)
    else $error("Nonzero inverse reported without an inverse.");

endmodule

// ===== dv/modular_inverse_ext_euclid_tb.sv =====
// Testbench for modular_inverse_ext_euclid: directed table and random operands under
// many moduli, each result compared with the table's value or an extended Euclid predictor.
// Depends on mie_pkg, the mie_*_if interfaces and the block itself.
module modular_inverse_ext_euclid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1450;
  localparam int IDLE_LIMIT = 25000;
  localparam int TAIL_CYCLES = 2000;

  typedef struct packed {
    mie_pkg::word_t inverse;
    logic           exists;
  } inv_result_t;

  typedef struct packed {
    logic           set_mod;
    mie_pkg::word_t modulus;
    mie_pkg::word_t value;
    logic           typed;
    mie_pkg::word_t inverse;
    logic           exists;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  mie_cfg_if    cfg_ch ();
  mie_value_if  value_ch ();
  mie_result_if result_ch ();

  modular_inverse_ext_euclid dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch.sink),
    .operand (value_ch.sink),
    .result  (result_ch.source)
  );

  inv_result_t    expected_q[$];
  mie_pkg::word_t modulus_now = mie_pkg::MODULUS_RESET;
  int             failures = 0;
  int             items_sent = 0;
  int             stall_left = 0;
  int             idle_cycles = 0;
  bit             quiet = 1'b0;

  stim_row_t directed_rows [23] = '{
    '{1'b0, 32'd0, 32'd1, 1'b1, 32'd1, 1'b1},
    '{1'b0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'd1000000007, 1'b1, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'd1000000008, 1'b1, 32'd1, 1'b1},
    '{1'b0, 32'd0, 32'd2, 1'b1, 32'd500000004, 1'b1},
    '{1'b0, 32'd0, 32'd1000000006, 1'b1, 32'd1000000006, 1'b1},
    '{1'b0, 32'd0, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
    '{1'b1, 32'd1, 32'd0, 1'b1, 32'd0, 1'b1},
    '{1'b0, 32'd0, 32'hFFFFFFFF, 1'b1, 32'd0, 1'b1},
    '{1'b1, 32'd0, 32'd5, 1'b1, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'hFFFFFFFF, 1'b1, 32'd0, 1'b0},
    '{1'b1, 32'hFFFFFFFF, 32'd2, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'd3, 1'b1, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'hFFFFFFFE, 1'b1, 32'hFFFFFFFE, 1'b1},
    '{1'b0, 32'd0, 32'hFFFFFFFF, 1'b1, 32'd0, 1'b0},
    '{1'b1, 32'd2, 32'd1, 1'b1, 32'd1, 1'b1},
    '{1'b0, 32'd0, 32'd2, 1'b1, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'hFFFFFFFF, 1'b1, 32'd1, 1'b1},
    '{1'b1, 32'h80000000, 32'h7FFFFFFF, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'd6, 1'b1, 32'd0, 1'b0},
    '{1'b1, 32'd2971215073, 32'd1836311903, 1'b0, 32'd0, 1'b0},
    '{1'b0, 32'd0, 32'd2971215072, 1'b1, 32'd2971215072, 1'b1}
  };

  always #2 clk = ~clk;

  function automatic inv_result_t predict_inverse(input mie_pkg::word_t m,
                                                  input mie_pkg::word_t v);
    longint unsigned r_prev, r_cur, r_next, q, t_prev, t_cur, t_next;
    int unsigned     steps;
    inv_result_t     res;
    res = '0;
    if (m != '0) begin
      r_prev = longint'(m);
      r_cur = longint'(v) % longint'(m);
      t_prev = 0;
      t_cur = 1;
      steps = 0;
      while (r_cur != 0) begin
        q = r_prev / r_cur;
        r_next = r_prev - q * r_cur;
        t_next = t_prev + q * t_cur;
        r_prev = r_cur;
        r_cur = r_next;
        t_prev = t_cur;
        t_cur = t_next;
        steps++;
      end
      if (r_prev == 1) begin
        res.exists = 1'b1;
        t_prev = t_prev % longint'(m);
        // The coefficient is negative after an even, nonzero number of steps.
        if (steps[0] == 1'b0 && t_prev != 0) begin
          res.inverse = mie_pkg::word_t'(longint'(m) - t_prev);
        end else begin
          res.inverse = mie_pkg::word_t'(t_prev);
        end
      end
    end
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 12) begin
      return 0;
    end
    if (r < 18) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic mie_pkg::word_t pick_modulus();
    mie_pkg::word_t m;
    case ($urandom_range(0, 9))
      0, 1: m = mie_pkg::word_t'($urandom_range(1, 255));
      2, 3: m = mie_pkg::word_t'($urandom_range(256, 65535));
      4, 5: m = mie_pkg::word_t'($urandom());
      6: m = mie_pkg::word_t'($urandom()) | 32'h80000000;
      7: m = mie_pkg::word_t'(1) << $urandom_range(0, 31);
      8: begin
        case ($urandom_range(0, 3))
          0: m = 32'd1;
          1: m = 32'd2;
          2: m = 32'hFFFFFFFF;
          default: m = mie_pkg::MODULUS_RESET;
        endcase
      end
      default: m = mie_pkg::word_t'($urandom_range(2, 50) * $urandom_range(2, 50)
                                   * $urandom_range(2, 1000));
    endcase
    return (m == '0) ? mie_pkg::word_t'(1) : m;
  endfunction

  function automatic mie_pkg::word_t pick_value(input mie_pkg::word_t m);
    mie_pkg::word_t v;
    case ($urandom_range(0, 11))
      5, 6: v = mie_pkg::word_t'($urandom()) % m;
      7: v = mie_pkg::word_t'($urandom_range(2, 7) * $urandom_range(0, 1 << 20));
      8: v = mie_pkg::word_t'(m * mie_pkg::word_t'($urandom_range(1, 4)));
      9: begin
        case ($urandom_range(0, 5))
          0: v = 32'd0;
          1: v = 32'd1;
          2: v = m - 1;
          3: v = m;
          4: v = m + 1;
          default: v = 32'hFFFFFFFF;
        endcase
      end
      default: v = mie_pkg::word_t'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_value(input mie_pkg::word_t v, input logic typed,
                            input inv_result_t typed_res);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      value_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value_ch.valid <= 1'b1;
    value_ch.value <= v;
    do @(posedge clk); while (!value_ch.ready);
    expected_q.insert(expected_q.size(),
                      typed ? typed_res : predict_inverse(modulus_now, v));
    items_sent++;
  endtask

  task automatic write_modulus(input mie_pkg::word_t m);
    value_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    modulus_now = m;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    inv_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got inverse=%0d exists=%0d",
                 $time, result_ch.inverse, result_ch.exists);
        failures++;
      end else begin
        want = expected_q.pop_front();
        if (result_ch.inverse !== want.inverse) begin
          $display("%0t: inverse mismatch, expected %0d, got %0d",
                   $time, want.inverse, result_ch.inverse);
          failures++;
        end
        if (result_ch.exists !== want.exists) begin
          $display("%0t: exists mismatch, expected %0d, got %0d",
                   $time, want.exists, result_ch.exists);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((value_ch.valid && value_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int             n_items;
    mie_pkg::word_t m;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    value_ch.valid <= 1'b0;
    value_ch.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_mod) begin
        write_modulus(directed_rows[i].modulus);
      end
      send_value(directed_rows[i].value, directed_rows[i].typed,
                 '{inverse: directed_rows[i].inverse, exists: directed_rows[i].exists});
    end

    while (items_sent < TOTAL_ITEMS) begin
      m = pick_modulus();
      write_modulus(m);
      quiet = ($urandom_range(0, 4) == 0);
      n_items = $urandom_range(20, 70);
      repeat (n_items) begin
        send_value(pick_value(m), 1'b0, '0);
      end
    end

    value_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mie_pkg.sv
sv/mie_if.sv
sv/mie_div.sv
sv/modular_inverse_ext_euclid.sv
dv/modular_inverse_ext_euclid_tb.sv
